// ----- hw/rtl/bsa_pkg.sv -----
package bsa_pkg;

    // Region geometry
    localparam int CELL_COUNT   = 256;
    localparam int HEADER_BYTES = 40;
    localparam int WORD_BITS    = 32;
    localparam int WORD_COUNT   = (CELL_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W        = $clog2(CELL_COUNT);
    localparam int WORD_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W        = $clog2(WORD_BITS);
    localparam int CNT_W        = $clog2(IDX_W);

    // Field and register widths
    localparam int ES_W     = 16;
    localparam int RSV_W    = 24;
    localparam int OFF_W    = 32;
    localparam int CIDX_W   = 8;
    localparam int STAT_W   = 2;
    localparam int BASE_W   = RSV_W + 1;
    localparam int SPAN_W   = ES_W + IDX_W;
    localparam int PROD_W   = ES_W + IDX_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Cells past the end of the last word read as busy
    localparam int LAST_BITS = CELL_COUNT - WORD_BITS * (WORD_COUNT - 1);
    localparam logic [WORD_BITS:0]   LAST_ONE = (WORD_BITS + 1)'(1) << LAST_BITS;
    localparam logic [WORD_BITS-1:0] PAD_MASK = ~(LAST_ONE[WORD_BITS-1:0] - 1'b1);

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_BYTES = 2'd1;

    // Controller states
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_ADD  = 8'b0000_1000,
        S_SUB  = 8'b0001_0000,
        S_CHK  = 8'b0010_0000,
        S_DIV  = 8'b0100_0000,
        S_CLR  = 8'b1000_0000
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan_next;
        logic mark;
        logic mul;
        logic sub;
        logic div_step;
        logic clear;
        logic emit_alloc;
        logic emit_full;
        logic emit_range;
        logic emit_free;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic word_free;
        logic last_word;
        logic below_base;
        logic zero_size;
        logic over_range;
        logic div_last;
    } t_sts;

endpackage

// ----- hw/rtl/bsa_ctrl.sv -----
module bsa_ctrl import bsa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic i_action,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy
);

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_action == ACT_FREE) ? S_SUB : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.word_free) begin
                    o_cmd.mark = 1'b1;
                    n_state    = S_MUL;
                end else if (i_sts.last_word) begin
                    o_cmd.emit_full = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.emit_alloc = 1'b1;
                n_state          = S_IDLE;
            end
            S_SUB: begin
                if (i_sts.zero_size || i_sts.below_base) begin
                    o_cmd.emit_range = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.sub = 1'b1;
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.over_range) begin
                    o_cmd.emit_range = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CLR;
                end
            end
            S_CLR: begin
                o_cmd.clear     = 1'b1;
                o_cmd.emit_free = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not leave idle");

    a_single_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.emit_alloc, o_cmd.emit_full, o_cmd.emit_range, o_cmd.emit_free}))
        else $error("more than one result emitted in a cycle");

endmodule

// ----- hw/rtl/bsa_datapath.sv -----
module bsa_datapath import bsa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic [OFF_W-1:0]     i_free_offset,
    output logic                 o_valid,
    output logic [STAT_W-1:0]    o_status,
    output logic [OFF_W-1:0]     o_cell_offset,
    output logic [CIDX_W-1:0]    o_cell_index
);

    // Lowest clear bit of a word
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] word);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    logic [ES_W-1:0]      r_elem_size;
    logic [RSV_W-1:0]     r_rsv;
    logic [WORD_BITS-1:0] r_bitmap [WORD_COUNT];
    logic [WORD_W-1:0]    r_widx;
    logic [OFF_W-1:0]     r_off;
    logic [OFF_W-1:0]     r_rem;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_q;
    logic [CNT_W-1:0]     r_cnt;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_valid;
    logic [STAT_W-1:0]    r_status;
    logic [OFF_W-1:0]     r_cell_off;
    logic [IDX_W-1:0]     r_cell_idx;

    logic [BASE_W-1:0]    base;
    logic [SPAN_W-1:0]    span;
    logic [SPAN_W-1:0]    dsh;
    logic                 div_ge;
    logic [WORD_W-1:0]    rd_addr;
    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] eff_word;
    logic [BIT_W-1:0]     free_bit;
    logic [WORD_W-1:0]    q_word;
    logic [BIT_W-1:0]     q_bit;
    logic [WORD_W-1:0]    idx_word;
    logic [BIT_W-1:0]     idx_bit;
    logic                 emit_any;

    assign o_cfg_ready = 1'b1;

    // Cell area start and byte span of all cells
    assign base = BASE_W'(HEADER_BYTES) + BASE_W'(r_rsv);
    assign span = SPAN_W'(r_elem_size) * SPAN_W'(CELL_COUNT);

    // Bitmap read port: scan word, or the word holding the freed cell
    assign q_word   = WORD_W'(r_q >> BIT_W);
    assign q_bit    = BIT_W'(r_q);
    assign idx_word = WORD_W'(r_idx >> BIT_W);
    assign idx_bit  = BIT_W'(r_idx);
    assign rd_addr  = i_cmd.clear ? q_word : r_widx;
    assign rd_word  = r_bitmap[rd_addr];
    assign eff_word = (r_widx == WORD_W'(WORD_COUNT - 1)) ? (rd_word | PAD_MASK) : rd_word;
    assign free_bit = first_zero(eff_word);

    // Divider trial subtract for the current quotient bit
    assign dsh    = SPAN_W'(r_elem_size) << r_cnt;
    assign div_ge = (r_rem[SPAN_W-1:0] >= dsh);

    // Status to the controller
    assign o_sts.word_free  = ~&eff_word;
    assign o_sts.last_word  = (r_widx == WORD_W'(WORD_COUNT - 1));
    assign o_sts.below_base = (r_off < OFF_W'(base));
    assign o_sts.zero_size  = (r_elem_size == '0);
    assign o_sts.over_range = (r_rem >= OFF_W'(span));
    assign o_sts.div_last   = (r_cnt == '0);

    assign emit_any = i_cmd.emit_alloc | i_cmd.emit_full | i_cmd.emit_range | i_cmd.emit_free;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem_size <= ES_W'(1);
            r_rsv       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ELEMENT_SIZE:   r_elem_size <= i_cfg_data[ES_W-1:0];
                CFG_RESERVED_BYTES: r_rsv       <= i_cfg_data[RSV_W-1:0];
                default: ;
            endcase
        end
    end

    // Occupancy bitmap: set on allocate, clear on free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < WORD_COUNT; w++) begin
                r_bitmap[w] <= '0;
            end
        end else if (i_cmd.mark) begin
            r_bitmap[rd_addr] <= rd_word | (WORD_BITS'(1) << free_bit);
        end else if (i_cmd.clear) begin
            r_bitmap[rd_addr] <= rd_word & ~(WORD_BITS'(1) << q_bit);
        end
    end

    // Working registers: scan pointer, offset, product, divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_widx <= '0;
            r_off  <= i_free_offset;
            r_cnt  <= CNT_W'(IDX_W - 1);
            r_q    <= '0;
        end
        if (i_cmd.scan_next) begin
            r_widx <= r_widx + 1'b1;
        end
        if (i_cmd.mark) begin
            r_idx <= IDX_W'({r_widx, free_bit});
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_idx) * PROD_W'(r_elem_size);
        end
        if (i_cmd.sub) begin
            r_rem <= r_off - OFF_W'(base);
        end
        if (i_cmd.div_step) begin
            if (div_ge) begin
                r_rem <= r_rem - OFF_W'(dsh);
            end
            r_q   <= {r_q[IDX_W-2:0], div_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= emit_any;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_alloc) begin
            r_status   <= ST_OK;
            r_cell_off <= OFF_W'(base) + OFF_W'(r_prod);
            r_cell_idx <= r_idx;
        end else if (i_cmd.emit_free) begin
            r_status   <= ST_OK;
            r_cell_off <= '0;
            r_cell_idx <= r_q;
        end else if (i_cmd.emit_full) begin
            r_status   <= ST_FULL;
            r_cell_off <= '0;
            r_cell_idx <= '0;
        end else if (i_cmd.emit_range) begin
            r_status   <= ST_RANGE;
            r_cell_off <= '0;
            r_cell_idx <= '0;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_cell_offset = r_cell_off;
    assign o_cell_index  = CIDX_W'(r_cell_idx);

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < OFF_W'(span)))
        else $error("divider remainder out of bound");

    a_mark_sets_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark |=> r_bitmap[idx_word][idx_bit])
        else $error("allocated cell not marked busy");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(emit_any))
        else $error("result strobe without emit");

endmodule

// ----- hw/rtl/bitmap_slot_allocator.sv -----
// Request flow: allocate scans the bitmap word by word, then multiplies and adds; a
// full map is reported after the last word; free runs an eight-step restoring
// divider by element size; an out-of-range free is rejected before the divider.
// One request at a time; a new request is taken in the cycle the result is shown.
// The receiver cannot stall: each result is flagged by o_valid for one cycle only.
// Synchronous active-low reset clears the bitmap (all cells free) and resets the config.
module bitmap_slot_allocator import bsa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [OFF_W-1:0]     i_free_offset,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                 o_valid,
    output logic [STAT_W-1:0]    o_status,
    output logic [OFF_W-1:0]     o_cell_offset,
    output logic [CIDX_W-1:0]    o_cell_index
);

    t_cmd cmd;
    t_sts sts;

    // Sequence each request
    bsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Bitmap, arithmetic and result registers
    bsa_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_free_offset (i_free_offset),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_cell_offset (o_cell_offset),
        .o_cell_index  (o_cell_index)
    );

endmodule
